// ===== rtl/bpm_pkg.sv =====
package bpm_pkg;

    localparam int MAP_W_BLOCKS = 256;
    localparam int MAP_H_BLOCKS = 256;
    localparam int MAX_PATCHES  = 4096;

    localparam int MAP_ENTRIES = MAP_W_BLOCKS * MAP_H_BLOCKS;
    localparam int ADDR_BITS   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int X_BITS      = (MAP_W_BLOCKS > 1) ? $clog2(MAP_W_BLOCKS) : 1;
    localparam int Y_BITS      = (MAP_H_BLOCKS > 1) ? $clog2(MAP_H_BLOCKS) : 1;
    localparam int MAP_W_BITS  = $clog2(MAP_W_BLOCKS + 1);
    localparam int MAP_H_BITS  = $clog2(MAP_H_BLOCKS + 1);
    localparam int COUNT_BITS  = $clog2(MAX_PATCHES + 1);

    localparam int ENTRY_BITS    = 16;
    localparam int CFG_DATA_BITS = 14;
    localparam logic [ENTRY_BITS-1:0] UNUSED_ENTRY = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_CLIPPED = 2'd2,
        STAT_OUTSIDE = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        CFG_LOG2_BLOCK = 2'd0,
        CFG_FRAME_W    = 2'd1,
        CFG_FRAME_H    = 2'd2,
        CFG_FIRST_WINS = 2'd3
    } cfg_idx_e;

    typedef enum logic [3:0] {
        ST_BOOT,
        ST_IDLE,
        ST_CLEAR,
        ST_ADD_PREP,
        ST_ADD_SETUP,
        ST_WALK,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } state_e;

    typedef struct packed {
        logic [1:0]  command;
        logic [12:0] pos_x;
        logic [12:0] pos_y;
        logic [13:0] size_x;
        logic [13:0] size_y;
        logic [7:0]  block_x;
        logic [7:0]  block_y;
    } in_item_t;

    typedef struct packed {
        logic [15:0] patch_index;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [2:0]            log2_block;
        logic                  first_wins;
        logic [MAP_W_BITS-1:0] map_w;
        logic [MAP_H_BITS-1:0] map_h;
    } cfg_t;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  rd_addr;
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [ENTRY_BITS-1:0] wr_data;
    } mem_req_t;

endpackage

// ===== rtl/bpm_cfg_regs.sv =====
module bpm_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  bpm_pkg::cfg_idx_e                cfg_index,
    input  logic [bpm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output bpm_pkg::cfg_t                    cfg
);
    import bpm_pkg::*;

    logic [2:0]  log2_reg;
    logic [13:0] frame_w_reg;
    logic [13:0] frame_h_reg;
    logic        first_wins_reg;

    logic [14:0] round_add;
    logic [14:0] w_blocks;
    logic [14:0] h_blocks;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            log2_reg       <= 3'd3;
            frame_w_reg    <= 14'd2048;
            frame_h_reg    <= 14'd2048;
            first_wins_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LOG2_BLOCK: log2_reg       <= cfg_data[2:0];
                CFG_FRAME_W:    frame_w_reg    <= cfg_data[13:0];
                CFG_FRAME_H:    frame_h_reg    <= cfg_data[13:0];
                CFG_FIRST_WINS: first_wins_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // map size in blocks: ceil(pixels / block), clamped to the physical map
    always_comb begin
        round_add = (15'd1 << log2_reg) - 15'd1;
        w_blocks  = ({1'b0, frame_w_reg} + round_add) >> log2_reg;
        h_blocks  = ({1'b0, frame_h_reg} + round_add) >> log2_reg;
        cfg.log2_block = log2_reg;
        cfg.first_wins = first_wins_reg;
        cfg.map_w = (w_blocks > 15'(MAP_W_BLOCKS)) ? MAP_W_BITS'(MAP_W_BLOCKS)
                                                   : MAP_W_BITS'(w_blocks);
        cfg.map_h = (h_blocks > 15'(MAP_H_BLOCKS)) ? MAP_H_BITS'(MAP_H_BLOCKS)
                                                   : MAP_H_BITS'(h_blocks);
    end

endmodule

// ===== rtl/bpm_map_ram.sv =====
module bpm_map_ram (
    input  logic                          clk,
    input  bpm_pkg::mem_req_t             req,
    output logic [bpm_pkg::ENTRY_BITS-1:0] rd_data
);
    import bpm_pkg::*;

    logic [ENTRY_BITS-1:0] mem [MAP_ENTRIES];
    logic [ENTRY_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bpm_ctrl.sv =====
module bpm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpm_pkg::cfg_t                  cfg,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  bpm_pkg::in_item_t              item,
    input  logic [bpm_pkg::ENTRY_BITS-1:0] rd_data,
    output bpm_pkg::mem_req_t              mem_req,
    output logic                           res_valid,
    input  logic                           res_ready,
    output bpm_pkg::out_item_t             res
);
    import bpm_pkg::*;

    // control state
    state_e                 state_reg, state_next;
    logic [ADDR_BITS-1:0]   clr_addr_reg, clr_addr_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   wr_pend_reg, wr_pend_next;

    // item and walk payload
    in_item_t               item_reg, item_next;
    logic [12:0]            x0_reg, x0_next;
    logic [12:0]            y0_reg, y0_next;
    logic [14:0]            w_reg, w_next;
    logic [14:0]            h_reg, h_next;
    logic [X_BITS-1:0]      cur_x_reg, cur_x_next;
    logic [Y_BITS-1:0]      cur_y_reg, cur_y_next;
    logic [X_BITS-1:0]      x_start_reg, x_start_next;
    logic [X_BITS-1:0]      x_last_reg, x_last_next;
    logic [Y_BITS-1:0]      y_last_reg, y_last_next;
    logic [ADDR_BITS-1:0]   wr_addr_reg, wr_addr_next;
    logic [ENTRY_BITS-1:0]  res_index_reg, res_index_next;
    logic [1:0]             res_status_reg, res_status_next;

    logic [14:0]            round_add;
    logic [15:0]            x1;
    logic [15:0]            y1;
    logic                   clip_x;
    logic                   clip_y;
    logic [MAP_W_BITS-1:0]  x1c;
    logic [MAP_H_BITS-1:0]  y1c;
    logic                   empty;
    logic [ADDR_BITS-1:0]   walk_addr;
    logic [ADDR_BITS-1:0]   read_addr;
    logic                   outside;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ST_BOOT;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            wr_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            wr_pend_reg  <= wr_pend_next;
        end
    end

    always_ff @(posedge clk) begin
        item_reg       <= item_next;
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        x_start_reg    <= x_start_next;
        x_last_reg     <= x_last_next;
        y_last_reg     <= y_last_next;
        wr_addr_reg    <= wr_addr_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
    end

    always_comb begin
        round_add = (15'd1 << cfg.log2_block) - 15'd1;
        x1     = 16'(x0_reg) + 16'(w_reg);
        y1     = 16'(y0_reg) + 16'(h_reg);
        clip_x = x1 > 16'(cfg.map_w);
        clip_y = y1 > 16'(cfg.map_h);
        x1c    = clip_x ? cfg.map_w : MAP_W_BITS'(x1);
        y1c    = clip_y ? cfg.map_h : MAP_H_BITS'(y1);
        empty  = (x0_reg >= 13'(x1c)) || (y0_reg >= 13'(y1c));
        walk_addr = ADDR_BITS'(cur_y_reg) * ADDR_BITS'(MAP_W_BLOCKS)
                  + ADDR_BITS'(cur_x_reg);
        read_addr = ADDR_BITS'(item_reg.block_y) * ADDR_BITS'(MAP_W_BLOCKS)
                  + ADDR_BITS'(item_reg.block_x);
        outside = (16'(item_reg.block_x) >= 16'(cfg.map_w))
               || (16'(item_reg.block_y) >= 16'(cfg.map_h));
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        count_next      = count_reg;
        wr_pend_next    = 1'b0;
        item_next       = item_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        x_start_next    = x_start_reg;
        x_last_next     = x_last_reg;
        y_last_next     = y_last_reg;
        wr_addr_next    = wr_addr_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;

        item_ready = 1'b0;
        res_valid  = 1'b0;

        // write stage of the walk: issued in the cycle after its read
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = walk_addr;
        mem_req.wr_en   = wr_pend_reg && (!cfg.first_wins || rd_data == UNUSED_ENTRY);
        mem_req.wr_addr = wr_addr_reg;
        mem_req.wr_data = res_index_reg;

        unique case (state_reg)
            ST_BOOT, ST_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_addr_reg;
                mem_req.wr_data = UNUSED_ENTRY;
                clr_addr_next   = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_BITS'(MAP_ENTRIES - 1)) begin
                    clr_addr_next = '0;
                    state_next    = (state_reg == ST_BOOT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    item_next       = item;
                    res_index_next  = UNUSED_ENTRY;
                    res_status_next = STAT_OK;
                    priority case (item.command)
                        CMD_CLEAR: begin
                            count_next = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_ADD:  state_next = ST_ADD_PREP;
                        CMD_READ: state_next = ST_RD_ISSUE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADD_PREP: begin
                if (count_reg >= COUNT_BITS'(MAX_PATCHES)) begin
                    res_status_next = STAT_DROPPED;
                    state_next      = ST_DONE;
                end else begin
                    x0_next    = item_reg.pos_x >> cfg.log2_block;
                    y0_next    = item_reg.pos_y >> cfg.log2_block;
                    w_next     = ({1'b0, item_reg.size_x} + round_add) >> cfg.log2_block;
                    h_next     = ({1'b0, item_reg.size_y} + round_add) >> cfg.log2_block;
                    state_next = ST_ADD_SETUP;
                end
            end
            ST_ADD_SETUP: begin
                res_index_next = ENTRY_BITS'(count_reg);
                count_next     = count_reg + 1'b1;
                if (w_reg != '0 && h_reg != '0 && (clip_x || clip_y)) begin
                    res_status_next = STAT_CLIPPED;
                end
                cur_x_next   = X_BITS'(x0_reg);
                cur_y_next   = Y_BITS'(y0_reg);
                x_start_next = X_BITS'(x0_reg);
                x_last_next  = X_BITS'(x1c - 1'b1);
                y_last_next  = Y_BITS'(y1c - 1'b1);
                state_next   = empty ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
                mem_req.rd_en = 1'b1;
                wr_pend_next  = 1'b1;
                wr_addr_next  = walk_addr;
                if (cur_x_reg == x_last_reg) begin
                    cur_x_next = x_start_reg;
                    if (cur_y_reg == y_last_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        cur_y_next = cur_y_reg + 1'b1;
                    end
                end else begin
                    cur_x_next = cur_x_reg + 1'b1;
                end
            end
            ST_RD_ISSUE: begin
                if (outside) begin
                    res_status_next = STAT_OUTSIDE;
                    state_next      = ST_DONE;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = read_addr;
                    state_next      = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT: begin
                res_index_next = rd_data;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        res.patch_index = res_index_reg;
        res.status      = res_status_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("map read and write hit the same entry in one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(MAX_PATCHES))
        else $error("patch count beyond maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (cur_x_reg <= x_last_reg && cur_y_reg <= y_last_reg
                                    && cur_x_reg >= x_start_reg))
        else $error("walk left its rectangle");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> $past(state_reg == ST_WALK))
        else $error("map write pending outside a walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_ready) |=> (state_reg == ST_IDLE && !wr_pend_reg))
        else $error("result handed off without returning to idle");

endmodule

// ===== rtl/block_to_patch_map_builder.sv =====
// Block-to-patch map builder. One transaction in gives one transaction out. A read registers
// its result after one map memory read (none when the block is outside the map); an add
// registers its result after a walk over every covered block inside the map, since the single
// write port of the map memory takes one block per cycle (read of the old entry issued in the
// cycle before its write). A dropped add and an empty one skip the walk. Once the result is
// registered the controller returns to idle and accepts the next item. A clear sweeps all
// 65536 map entries, one per cycle, before its result appears, and the same sweep runs after
// reset, during which no transaction is accepted on the item channel (configuration writes
// are taken at all times). A finished result sits in an output register, so the next item is
// accepted while the previous result waits.
module block_to_patch_map_builder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  bpm_pkg::in_item_t                 item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output bpm_pkg::out_item_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  bpm_pkg::cfg_idx_e                 cfg_index,
    input  logic [bpm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import bpm_pkg::*;

    cfg_t                  cfg;
    mem_req_t              mem_req;
    logic [ENTRY_BITS-1:0] rd_data;
    logic                  res_valid;
    logic                  res_ready;
    out_item_t             res;

    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    assign cfg_ready = 1'b1;

    bpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpm_map_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    bpm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .rd_data    (rd_data),
        .mem_req    (mem_req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (result_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (res_valid && res_ready) begin
            out_item_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
